### src/cbd_pkg.sv
`timescale 1ns / 1ps

package cbd_pkg;

   localparam int unsigned DATA_W = 32;

   // request codes
   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd1;
   localparam logic [1:0] REQ_PUSH_BACK  = 2'd2;
   localparam logic [1:0] REQ_POP_BACK   = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;
   localparam logic signed [DATA_W-1:0] PUSH_WORD  = '0;

   typedef enum logic {
      S_IDLE,
      S_XFER
   } cbd_state_type;

   typedef struct packed {
      logic accept;
      logic load;
   } cbd_cmd_type;

   typedef struct packed {
      logic out_busy;
   } cbd_sts_type;

endpackage

### src/cbd_ctrl.sv
`timescale 1ns / 1ps

module cbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cbd_pkg::cbd_sts_type sts,
   output cbd_pkg::cbd_cmd_type cmd
);

   cbd_pkg::cbd_state_type state_ff;
   cbd_pkg::cbd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.load   = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         cbd_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = cbd_pkg::S_XFER;
            end
         end
         cbd_pkg::S_XFER: begin
            // wait for the output register to drain
            if (!sts.out_busy) begin
               cmd.load = 1'b1;
               state_in = cbd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cbd_pkg::S_IDLE;
         end
      endcase
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !sts.out_busy)
      else $error("result moved into a busy output register");

   a_accept_then_xfer: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == cbd_pkg::S_XFER) && req_stall)
      else $error("accepted beat not followed by transfer");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.load))
      else $error("accept and load in one cycle");

endmodule

### src/cbd_dpath.sv
`timescale 1ns / 1ps

module cbd_dpath #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cbd_pkg::cbd_cmd_type               cmd,
   output cbd_pkg::cbd_sts_type               sts,
   input  logic [1:0]                         req_type,
   input  logic signed [cbd_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cbd_pkg::DATA_W-1:0]  rsp_data,
   output logic [1:0]                         rsp_status
);

   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned CNT_W = AW + 1;

   logic [cbd_pkg::DATA_W-1:0] mem [DEPTH];

   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             pend_mem_ff, pend_mem_in;
   logic signed [cbd_pkg::DATA_W-1:0] pend_data_ff, pend_data_in;
   logic [1:0]       pend_status_ff, pend_status_in;

   logic             rsp_valid_ff;
   logic signed [cbd_pkg::DATA_W-1:0] rsp_data_ff;
   logic [1:0]       rsp_status_ff;

   logic [cbd_pkg::DATA_W-1:0] rd_data_ff;

   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic             is_full, is_empty;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      pend_mem_in    = pend_mem_ff;
      pend_data_in   = pend_data_ff;
      pend_status_in = pend_status_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      wr_addr        = tail_ff;
      rd_addr        = head_ff;
      if (cmd.accept) begin
         pend_mem_in    = 1'b0;
         pend_data_in   = cbd_pkg::PUSH_WORD;
         pend_status_in = cbd_pkg::STAT_OK;
         unique case (req_type)
            cbd_pkg::REQ_PUSH_FRONT: begin
               if (is_full) begin
                  pend_status_in = cbd_pkg::STAT_FULL;
               end else begin
                  head_in  = head_ff - AW'(1);
                  wr_addr  = head_ff - AW'(1);
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            cbd_pkg::REQ_PUSH_BACK: begin
               if (is_full) begin
                  pend_status_in = cbd_pkg::STAT_FULL;
               end else begin
                  tail_in  = tail_ff + AW'(1);
                  wr_addr  = tail_ff;
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            cbd_pkg::REQ_POP_FRONT: begin
               if (is_empty) begin
                  pend_data_in   = cbd_pkg::EMPTY_WORD;
                  pend_status_in = cbd_pkg::STAT_EMPTY;
               end else begin
                  head_in     = head_ff + AW'(1);
                  rd_addr     = head_ff;
                  rd_en       = 1'b1;
                  pend_mem_in = 1'b1;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            cbd_pkg::REQ_POP_BACK: begin
               if (is_empty) begin
                  pend_data_in   = cbd_pkg::EMPTY_WORD;
                  pend_status_in = cbd_pkg::STAT_EMPTY;
               end else begin
                  tail_in     = tail_ff - AW'(1);
                  rd_addr     = tail_ff - AW'(1);
                  rd_en       = 1'b1;
                  pend_mem_in = 1'b1;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            default: begin
               pend_status_in = cbd_pkg::STAT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_mem_ff    <= pend_mem_in;
      pend_data_ff   <= pend_data_in;
      pend_status_ff <= pend_status_in;
   end

   // output register, parts the result side from the request side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff   <= pend_mem_ff ? $signed(rd_data_ff) : pend_data_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign sts.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      AW'(tail_ff - head_ff) == count_ff[AW-1:0])
      else $error("pointers disagree with entry count");

   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store written and read for one beat");

endmodule

### src/circular_buffer_deque.sv
`timescale 1ns / 1ps
// channel  | valid     | stall     | payload
// request  | req_valid | req_stall | req_type[1:0], req_value[31:0]
// response | rsp_valid | rsp_stall | rsp_data[31:0], rsp_status[1:0]
//
// one beat at a time: each request passes the registered store read and
// then the move into the output register, which waits while rsp_stall holds it
// a new request is taken while the previous response still waits
// synchronous reset clears head, tail and entry count; store contents stay
// undefined until pushed, with no clearing pass
// a stalled response holds; the next request waits on req_stall until the
// output register has taken the result before it

module circular_buffer_deque #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic signed [cbd_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cbd_pkg::DATA_W-1:0]  rsp_data,
   output logic [1:0]                         rsp_status
);

   cbd_pkg::cbd_cmd_type cmd;
   cbd_pkg::cbd_sts_type sts;

   cbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbd_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_type   (req_type),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status)
   );

endmodule
